FILE: hdl/morse_key_decoder_assert.svh
// ----------------------------------------------------------------------------
// Morse key decoder assertion macros
// Concurrent assertion helpers that drop out of synthesis builds.
// ----------------------------------------------------------------------------
`ifndef MORSE_KEY_DECODER_ASSERT_SVH
`define MORSE_KEY_DECODER_ASSERT_SVH

`ifndef SYNTHESIS
// The antecedent implies the consequent in the same cycle.
`define MKD_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// The antecedent implies the consequent in the next cycle.
`define MKD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define MKD_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define MKD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: hdl/mkd_pkg.sv
// ----------------------------------------------------------------------------
// Morse key decoder package
// Shared constants, types and the letter lookup for the Morse key decoder.
// ----------------------------------------------------------------------------
package mkd_pkg;

   // Pattern and timer sizes.
   localparam int MAX_SYMBOLS = 9;
   localparam int TIMER_BITS  = 16;
   localparam int COUNT_BITS  = $clog2(MAX_SYMBOLS + 1);
   localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

   // Configuration register layout. The timer compares assume 16-bit thresholds.
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DASH_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LETTER_GAP     = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEBOUNCE_TICKS = 2'd2;

   localparam logic [15:0] RESET_DASH_THRESHOLD = 16'd400;
   localparam logic [15:0] RESET_LETTER_GAP     = 16'd1200;
   localparam logic [7:0]  RESET_DEBOUNCE_TICKS = 8'd20;

   // Character codes.
   localparam logic [6:0] CHAR_A       = 7'h41;
   localparam logic [6:0] CHAR_UNKNOWN = 7'h3F;
   localparam int         LETTER_COUNT = 26;

   // Letter table: symbol count and pattern (dash = 1, newest symbol in bit 0).
   localparam logic [2:0] LETTER_LEN [LETTER_COUNT] = '{
      3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2,
      3'd4, 3'd3, 3'd4, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3,
      3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
   };
   localparam logic [3:0] LETTER_BITS [LETTER_COUNT] = '{
      4'd1, 4'd8, 4'd10, 4'd4, 4'd0, 4'd2, 4'd6, 4'd0, 4'd0,
      4'd7, 4'd5, 4'd4,  4'd3, 4'd2, 4'd7, 4'd6, 4'd13, 4'd2,
      4'd0, 4'd1, 4'd1,  4'd1, 4'd3, 4'd9, 4'd11, 4'd12
   };

   typedef enum logic [1:0] {
      EVENT_NONE   = 2'd0,
      EVENT_DOT    = 2'd1,
      EVENT_DASH   = 2'd2,
      EVENT_LETTER = 2'd3
   } event_kind_type;

   typedef struct packed {
      logic [15:0] dash_threshold;
      logic [15:0] letter_gap;
      logic [7:0]  debounce_ticks;
   } mkd_cfg_type;

   typedef struct packed {
      event_kind_type event_kind;
      logic [6:0]     letter_code;
      logic           lamp_on;
      logic           tone_level;
   } mkd_rsp_type;

   typedef struct packed {
      logic main_valid;
      logic skid_valid;
   } mkd_buf_status_type;

   // Decode a symbol count and pattern to a letter, or to a question mark.
   function automatic logic [6:0] lookup_letter(input logic [COUNT_BITS-1:0]  count,
                                                input logic [MAX_SYMBOLS-1:0] pattern);
      logic [6:0] code;
      code = CHAR_UNKNOWN;
      for (int i = LETTER_COUNT - 1; i >= 0; i--) begin
         if (count == COUNT_BITS'(LETTER_LEN[i]) &&
             pattern == MAX_SYMBOLS'(LETTER_BITS[i])) begin
            code = CHAR_A + 7'(i);
         end
      end
      return code;
   endfunction

endpackage

FILE: hdl/mkd_req_if.sv
// ----------------------------------------------------------------------------
// Morse key decoder request channel
// Valid/ready channel that carries one key sample per tick.
// ----------------------------------------------------------------------------
interface mkd_req_if;
   logic valid;
   logic ready;
   logic key_level;

   modport source (output valid, output key_level, input ready);
   modport sink   (input valid, input key_level, output ready);
endinterface

FILE: hdl/mkd_rsp_if.sv
// ----------------------------------------------------------------------------
// Morse key decoder response channel
// Valid/ready channel that carries one decode result per tick.
// ----------------------------------------------------------------------------
interface mkd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] event_kind;
   logic [6:0] letter_code;
   logic       lamp_on;
   logic       tone_level;

   modport source (output valid, output event_kind, output letter_code,
                   output lamp_on, output tone_level, input ready);
   modport sink   (input valid, input event_kind, input letter_code,
                   input lamp_on, input tone_level, output ready);
endinterface

FILE: hdl/mkd_csr.sv
// ----------------------------------------------------------------------------
// Morse key decoder configuration registers
// Holds dash threshold, letter gap and debounce length, written by index.
// ----------------------------------------------------------------------------
module mkd_csr
   import mkd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      write_en,
   input  logic [CSR_INDEX_BITS-1:0] index,
   input  logic [CSR_DATA_BITS-1:0]  wdata,
   output mkd_cfg_type               cfg
);

   mkd_cfg_type cfg_ff;
   mkd_cfg_type cfg_in;

   // Register decode; unused indexes leave everything unchanged.
   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            CSR_DASH_THRESHOLD: cfg_in.dash_threshold = wdata;
            CSR_LETTER_GAP:     cfg_in.letter_gap     = wdata;
            CSR_DEBOUNCE_TICKS: cfg_in.debounce_ticks = wdata[7:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dash_threshold <= RESET_DASH_THRESHOLD;
         cfg_ff.letter_gap     <= RESET_LETTER_GAP;
         cfg_ff.debounce_ticks <= RESET_DEBOUNCE_TICKS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: hdl/mkd_core.sv
// ----------------------------------------------------------------------------
// Morse key decoder core
// Debounce, hold timing, symbol collection and letter decode for one tick.
// ----------------------------------------------------------------------------
module mkd_core
   import mkd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mkd_cfg_type cfg,
   input  logic        take,
   input  logic        key_level,
   output mkd_rsp_type result
);

   logic                   stable_ff,  stable_in;
   logic [7:0]             wait_ff,    wait_in;
   logic                   tone_ff,    tone_in;
   logic [TIMER_BITS-1:0]  hold_ff,    hold_in;
   logic [TIMER_BITS-1:0]  idle_ff,    idle_in;
   logic [COUNT_BITS-1:0]  count_ff,   count_in;
   logic [MAX_SYMBOLS-1:0] pattern_ff, pattern_in;
   logic                   pin_ff,     pin_in;

   logic           recheck;
   logic           waiting;
   logic           is_dash;
   event_kind_type kind;
   logic [6:0]     code;

   // Next state and result for the tick being transferred.
   always_comb begin
      stable_in  = stable_ff;
      wait_in    = wait_ff;
      tone_in    = tone_ff;
      hold_in    = hold_ff;
      idle_in    = idle_ff;
      count_in   = count_ff;
      pattern_in = pattern_ff;
      pin_in     = pin_ff;
      recheck    = 1'b0;
      waiting    = 1'b0;
      is_dash    = 1'b0;
      kind       = EVENT_NONE;
      code       = '0;

      // Saturating timers.
      if (tone_ff && hold_ff != TIMER_MAX) begin
         hold_in = hold_ff + 1'b1;
      end
      if (count_ff != '0 && idle_ff != TIMER_MAX) begin
         idle_in = idle_ff + 1'b1;
      end

      // Debounce: a level change starts a wait, the last wait tick re-samples.
      if (wait_ff != '0) begin
         wait_in = wait_ff - 1'b1;
         if (wait_in == '0) begin
            recheck = 1'b1;
         end else begin
            waiting = 1'b1;
         end
      end else if (key_level != stable_ff) begin
         if (cfg.debounce_ticks == '0) begin
            recheck = 1'b1;
         end else begin
            wait_in = cfg.debounce_ticks;
            waiting = 1'b1;
         end
      end

      // Confirmed press or release.
      if (recheck) begin
         if (!key_level && stable_ff && !tone_ff) begin
            tone_in = 1'b1;
            hold_in = '0;
         end else if (key_level && !stable_ff && tone_ff) begin
            is_dash = (hold_in >= cfg.dash_threshold);
            tone_in = 1'b0;
            kind    = is_dash ? EVENT_DASH : EVENT_DOT;
            if (count_ff < COUNT_BITS'(MAX_SYMBOLS)) begin
               pattern_in = {pattern_ff[MAX_SYMBOLS-2:0], is_dash};
               count_in   = count_ff + 1'b1;
            end
            idle_in = '0;
         end
         stable_in = key_level;
      end

      // Buzzer toggle and letter decode happen only on processed ticks.
      if (!waiting) begin
         if (tone_in) begin
            pin_in = ~pin_ff;
         end
         if (kind == EVENT_NONE && count_in != '0 && idle_in > cfg.letter_gap) begin
            kind       = EVENT_LETTER;
            code       = lookup_letter(count_in, pattern_in);
            count_in   = '0;
            pattern_in = '0;
            idle_in    = '0;
         end
      end

      result.event_kind  = kind;
      result.letter_code = code;
      result.lamp_on     = tone_in;
      result.tone_level  = pin_in;
   end

   // State advances only when a tick is transferred.
   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff  <= 1'b1;
         wait_ff    <= '0;
         tone_ff    <= 1'b0;
         hold_ff    <= '0;
         idle_ff    <= '0;
         count_ff   <= '0;
         pattern_ff <= '0;
         pin_ff     <= 1'b0;
      end else if (take) begin
         stable_ff  <= stable_in;
         wait_ff    <= wait_in;
         tone_ff    <= tone_in;
         hold_ff    <= hold_in;
         idle_ff    <= idle_in;
         count_ff   <= count_in;
         pattern_ff <= pattern_in;
         pin_ff     <= pin_in;
      end
   end

endmodule

FILE: hdl/mkd_rsp_buffer.sv
// ----------------------------------------------------------------------------
// Morse key decoder response buffer
// Output register plus skid stage; input is blocked only when both are full.
// ----------------------------------------------------------------------------
module mkd_rsp_buffer
   import mkd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  mkd_rsp_type        in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output mkd_rsp_type        out_data,
   output mkd_buf_status_type status
);

   logic        main_valid_ff, main_valid_in;
   logic        skid_valid_ff, skid_valid_in;
   mkd_rsp_type main_ff;
   mkd_rsp_type skid_ff;
   logic        push;
   logic        pop;
   logic        main_free;

   assign in_ready  = !skid_valid_ff;
   assign push      = in_valid && in_ready;
   assign pop       = main_valid_ff && out_ready;
   assign main_free = !main_valid_ff || pop;

   // Occupancy: the skid stage fills only when the output register stays full.
   always_comb begin
      main_valid_in = main_free ? (skid_valid_ff || push) : 1'b1;
      skid_valid_in = skid_valid_ff;
      if (push && !main_free) begin
         skid_valid_in = 1'b1;
      end else if (pop) begin
         skid_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Payload moves: skid entry is older, so it refills the output first.
   always_ff @(posedge clock) begin
      if (main_free) begin
         if (skid_valid_ff) begin
            main_ff <= skid_ff;
         end else if (push) begin
            main_ff <= in_data;
         end
      end
      if (push && !main_free) begin
         skid_ff <= in_data;
      end
   end

   assign out_valid         = main_valid_ff;
   assign out_data          = main_ff;
   assign status.main_valid = main_valid_ff;
   assign status.skid_valid = skid_valid_ff;

endmodule

FILE: hdl/morse_key_decoder.sv
// ----------------------------------------------------------------------------
// Morse key decoder
// Single-key Morse decoder with debounce, dot/dash timing and letter output.
// ----------------------------------------------------------------------------
// Usage: each transfer on req_bus is one timer tick carrying key_level
// (0 pressed, 1 released). Every transfer yields exactly one transfer on
// rsp_bus with event_kind (none, dot, dash or letter), letter_code (A to Z or
// a question mark on a letter event, else 0), lamp_on and tone_level.
// The csr_ port writes dash_threshold, letter_gap and debounce_ticks by index;
// index 3 is ignored. The user must write them only while the block is idle;
// the block itself does not enforce it. The result on rsp_bus is registered.
// Throughput: one tick per cycle while req_bus.ready is high, set by the single
// pass through the core logic into the output register.
// A stalled receiver is absorbed by a two-entry output buffer (output register
// plus skid stage); req_bus.ready drops only when both entries are full.
// Reset is synchronous and active high: registers return to their reset
// values, the key is taken as released and the buffer empties.
// ----------------------------------------------------------------------------
`include "morse_key_decoder_assert.svh"

module morse_key_decoder
   import mkd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   mkd_req_if.sink                   req_bus,
   mkd_rsp_if.source                 rsp_bus,
   input  logic                      csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   mkd_cfg_type        cfg;
   mkd_rsp_type        core_result;
   mkd_rsp_type        rsp_data;
   mkd_buf_status_type buf_status;
   logic               req_ready;
   logic               req_take;

   // Configuration registers.
   mkd_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .write_en (csr_write_en),
      .index    (csr_index),
      .wdata    (csr_wdata),
      .cfg      (cfg)
   );

   // A tick advances the core whenever the buffer takes its result.
   assign req_bus.ready = req_ready;
   assign req_take      = req_bus.valid && req_ready;

   mkd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .take      (req_take),
      .key_level (req_bus.key_level),
      .result    (core_result)
   );

   // Output register and skid stage.
   mkd_rsp_buffer u_rsp_buffer (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_ready),
      .in_data   (core_result),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_data  (rsp_data),
      .status    (buf_status)
   );

   assign rsp_bus.event_kind  = rsp_data.event_kind;
   assign rsp_bus.letter_code = rsp_data.letter_code;
   assign rsp_bus.lamp_on     = rsp_data.lamp_on;
   assign rsp_bus.tone_level  = rsp_data.tone_level;

   // Checks on buffer ordering and result consistency.
   `MKD_ASSERT_IMPLIES(a_skid_needs_main, clock, reset, buf_status.skid_valid, buf_status.main_valid)
   `MKD_ASSERT_NEXT(a_req_gives_rsp, clock, reset, req_take, rsp_bus.valid)
   `MKD_ASSERT_IMPLIES(a_letter_has_code, clock, reset, rsp_bus.valid && rsp_bus.event_kind == EVENT_LETTER, rsp_bus.letter_code != 7'd0)
   `MKD_ASSERT_IMPLIES(a_symbol_no_code, clock, reset, rsp_bus.valid && rsp_bus.event_kind != EVENT_LETTER, rsp_bus.letter_code == 7'd0)

endmodule
